FILE: hdl/byte_ring_fifo_top_defines.svh
// Assertion macros for the byte ring FIFO.
`ifndef BYTE_RING_FIFO_TOP_DEFINES_SVH
`define BYTE_RING_FIFO_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define BRF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define BRF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define BRF_ASSERT(lbl, prop, msg)
`define BRF_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

FILE: hdl/brf_pkg.sv
package brf_pkg;

	localparam int DEPTH_DEFAULT = 1024;
	localparam int CFG_W         = 11;
	localparam int SIZE_RESET    = 1024;

	localparam logic [1:0] KIND_WRITE      = 2'd0;
	localparam logic [1:0] KIND_READ       = 2'd1;
	localparam logic [1:0] KIND_BURST_HDR  = 2'd2;
	localparam logic [1:0] KIND_BURST_BYTE = 2'd3;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  data;
		logic [15:0] burst_length;
	} in_item_t;

	typedef struct packed {
		logic        ok;
		logic [7:0]  read_data;
		logic [9:0]  occupancy;
		logic [9:0]  free_space;
		logic        is_empty;
		logic        is_full;
		logic [31:0] failure_count;
	} out_item_t;

	typedef struct packed {
		logic exec;
		logic load;
		logic cfg_wr;
	} brf_cmd_t;

endpackage

FILE: hdl/brf_ctrl.sv
module brf_ctrl
	import brf_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	output logic     out_valid,
	input  logic     out_stall,
	input  logic     cfg_valid,
	output logic     cfg_ready,
	output brf_cmd_t cmd
);

	typedef enum logic {
		S_IDLE,
		S_DONE
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	assign cfg_ready  = (state_q == S_IDLE);
	assign in_stall   = (state_q != S_IDLE) || cfg_valid;
	assign out_valid  = out_valid_q;

	assign cmd.cfg_wr = cfg_valid && cfg_ready;
	assign cmd.exec   = in_valid && !in_stall;
	assign cmd.load   = (state_q == S_DONE) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= cmd.load || (out_valid_q && out_stall);
			unique case (state_q)
				S_IDLE: begin
					if (cmd.exec) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (cmd.load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

FILE: hdl/brf_dp.sv
module brf_dp
	import brf_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEFAULT
) (
	input  logic             clk,
	input  logic             arst_n,
	input  brf_cmd_t         cmd,
	input  in_item_t         in_item,
	input  logic [CFG_W-1:0] cfg_data,
	output out_item_t        out_item
);

	localparam int AW = $clog2(DEPTH);
	localparam int SW = $clog2(DEPTH + 1);
	localparam int XW = SW + 1;
	localparam int SIZE_INIT = (SIZE_RESET > DEPTH) ? DEPTH : SIZE_RESET;

	logic [7:0]    mem [DEPTH];
	logic [7:0]    rd_data_q;

	logic [SW-1:0] size_q;
	logic [AW-1:0] wr_idx_q;
	logic [AW-1:0] rd_idx_q;
	logic [31:0]   fail_q;
	logic          burst_open_q;
	logic [15:0]   burst_rem_q;
	logic          ok_q;
	logic          read_hit_q;
	out_item_t     out_item_q;

	logic [31:0]   cfg_ext;
	logic [SW-1:0] size_clamped;
	logic [XW-1:0] size_x;
	logic [XW-1:0] wr_x;
	logic [XW-1:0] rd_x;
	logic [XW-1:0] fill;
	logic [XW-1:0] free_now;
	logic [XW-1:0] wr_inc_x;
	logic [XW-1:0] rd_inc_x;
	logic [AW-1:0] wr_wrap;
	logic [AW-1:0] rd_wrap;
	logic          is_full;
	logic          is_empty;
	logic          push_ok;
	logic          mem_we;
	logic          mem_re;
	logic [15:0]   rem_dec;

	always_comb begin
		cfg_ext = 32'(cfg_data);
		if (cfg_ext < 32'd2) begin
			size_clamped = SW'(2);
		end else if (cfg_ext > 32'(DEPTH)) begin
			size_clamped = SW'(DEPTH);
		end else begin
			size_clamped = SW'(cfg_ext);
		end
	end

	assign size_x   = XW'(size_q);
	assign wr_x     = XW'(wr_idx_q);
	assign rd_x     = XW'(rd_idx_q);
	assign fill     = (wr_x >= rd_x) ? (wr_x - rd_x) : (wr_x + size_x - rd_x);
	assign free_now = size_x - XW'(1) - fill;
	assign wr_inc_x = wr_x + XW'(1);
	assign rd_inc_x = rd_x + XW'(1);
	assign wr_wrap  = (wr_inc_x == size_x) ? '0 : wr_inc_x[AW-1:0];
	assign rd_wrap  = (rd_inc_x == size_x) ? '0 : rd_inc_x[AW-1:0];
	assign is_full  = (wr_wrap == rd_idx_q);
	assign is_empty = (wr_idx_q == rd_idx_q);
	assign rem_dec  = burst_rem_q - 16'd1;

	always_comb begin
		push_ok = 1'b0;
		mem_we  = 1'b0;
		mem_re  = 1'b0;
		if (cmd.exec) begin
			unique case (in_item.kind)
				KIND_WRITE: begin
					push_ok = !is_full;
					mem_we  = !is_full;
				end
				KIND_READ: begin
					mem_re = !is_empty;
				end
				KIND_BURST_HDR: begin
				end
				KIND_BURST_BYTE: begin
					push_ok = burst_open_q && !is_full;
					mem_we  = burst_open_q && !is_full;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_idx_q] <= in_item.data;
		end
		if (mem_re) begin
			rd_data_q <= mem[rd_idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q       <= SW'(SIZE_INIT);
			wr_idx_q     <= '0;
			rd_idx_q     <= '0;
			fail_q       <= '0;
			burst_open_q <= 1'b0;
			burst_rem_q  <= '0;
			ok_q         <= 1'b0;
			read_hit_q   <= 1'b0;
		end else if (cmd.cfg_wr) begin
			size_q       <= size_clamped;
			wr_idx_q     <= '0;
			rd_idx_q     <= '0;
			fail_q       <= '0;
			burst_open_q <= 1'b0;
			burst_rem_q  <= '0;
		end else if (cmd.exec) begin
			ok_q       <= 1'b0;
			read_hit_q <= 1'b0;
			unique case (in_item.kind)
				KIND_WRITE: begin
					ok_q <= push_ok;
					if (push_ok) begin
						wr_idx_q <= wr_wrap;
					end else begin
						fail_q <= fail_q + 32'd1;
					end
				end
				KIND_READ: begin
					if (!is_empty) begin
						rd_idx_q   <= rd_wrap;
						ok_q       <= 1'b1;
						read_hit_q <= 1'b1;
					end
				end
				KIND_BURST_HDR: begin
					if (32'(free_now) < 32'(in_item.burst_length)) begin
						fail_q       <= fail_q + 32'd1;
						burst_open_q <= 1'b0;
						burst_rem_q  <= '0;
					end else begin
						ok_q         <= 1'b1;
						burst_open_q <= (in_item.burst_length != 16'd0);
						burst_rem_q  <= in_item.burst_length;
					end
				end
				KIND_BURST_BYTE: begin
					if (burst_open_q) begin
						ok_q        <= push_ok;
						burst_rem_q <= rem_dec;
						if (rem_dec == 16'd0) begin
							burst_open_q <= 1'b0;
						end
						if (push_ok) begin
							wr_idx_q <= wr_wrap;
						end else begin
							fail_q <= fail_q + 32'd1;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_item_q.ok            <= ok_q;
			out_item_q.read_data     <= read_hit_q ? rd_data_q : 8'd0;
			out_item_q.occupancy     <= 10'(fill);
			out_item_q.free_space    <= 10'(size_x - XW'(1) - fill);
			out_item_q.is_empty      <= is_empty;
			out_item_q.is_full       <= is_full;
			out_item_q.failure_count <= fail_q;
		end
	end

	assign out_item = out_item_q;

endmodule

FILE: hdl/byte_ring_fifo_top.sv
// An item is executed in S_IDLE and its result is loaded in S_DONE once the
// output is free; the two-state controller stalls the input until then, and
// the byte store has a registered read port. A stalled result holds the next.
// Reset clears the indices, failure count and burst state and sets the size to
// 1024 slots (or DEPTH if smaller); the byte store is not cleared.
`include "byte_ring_fifo_top_defines.svh"

module byte_ring_fifo_top
	import brf_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEFAULT
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  in_item_t         in_item,
	output logic             out_valid,
	input  logic             out_stall,
	output out_item_t        out_item,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CFG_W-1:0] cfg_data
);

	brf_cmd_t cmd;

	brf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cmd       (cmd)
	);

	brf_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_item  (in_item),
		.cfg_data (cfg_data),
		.out_item (out_item)
	);

	`BRF_ASSERT(a_cfg_excl, (cmd.exec |-> !cmd.cfg_wr), "item and config transfer collide")
	`BRF_ASSERT_NEXT(a_busy_after, cmd.exec, in_stall, "input not stalled while item in work")
	`BRF_ASSERT(a_not_both, (out_valid |-> !(out_item.is_empty && out_item.is_full)), "empty and full")
	`BRF_ASSERT(a_empty_occ, (out_valid && out_item.is_empty |-> out_item.occupancy == 10'd0), "empty with data")

endmodule
